@@ src/mck_pkg.sv @@
// Shared types and constants for the Morse character keyer.
// Used by the front end, request queue, back end and top level.
package mck_pkg;

  localparam int CharW = 8;
  localparam int DurW  = 8;
  localparam int GapW  = 8;

  localparam logic [1:0] KIND_LETTER  = 2'd0;
  localparam logic [1:0] KIND_SPACE   = 2'd1;
  localparam logic [1:0] KIND_INVALID = 2'd2;

  localparam logic [1:0] CFG_SYMBOL_GAP = 2'd0;
  localparam logic [1:0] CFG_LETTER_GAP = 2'd1;
  localparam logic [1:0] CFG_WORD_GAP   = 2'd2;

  localparam logic [DurW-1:0] DOT_TICKS  = 8'd1;
  localparam logic [DurW-1:0] DASH_TICKS = 8'd3;

  localparam logic [CharW-1:0] CASE_MASK   = 8'hDF;
  localparam logic [CharW-1:0] SPACE_CHAR  = 8'h20;
  localparam logic [CharW-1:0] FIRST_UPPER = 8'h41;
  localparam logic [CharW-1:0] LAST_UPPER  = 8'h5A;

  // High nibble: symbol count; low nibble bit i: symbol i is a dash.
  localparam logic [7:0] LETTER_CODE [32] = '{
    8'h22, 8'h41, 8'h45, 8'h31, 8'h10, 8'h44, 8'h33, 8'h40,
    8'h20, 8'h4E, 8'h35, 8'h42, 8'h23, 8'h21, 8'h37, 8'h46,
    8'h4B, 8'h32, 8'h30, 8'h11, 8'h34, 8'h48, 8'h36, 8'h49,
    8'h4D, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] count;
    logic [3:0] dash;
  } desc_t;

  typedef struct packed {
    logic [GapW-1:0] symbol_gap;
    logic [GapW-1:0] letter_gap;
    logic [GapW-1:0] word_gap;
  } gaps_t;

endpackage

@@ src/morse_character_keyer.sv @@
// Morse character keyer top level: gap registers, front end, queue, back end.
// Depends on mck_pkg, mck_front, mck_queue and mck_back.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata[7:0] character
//  out_    | out | out_tvalid/out_tready| tdata light_on, duration; tlast last; tuser invalid
//  cfg_    | in  | cfg_we               | cfg_index, cfg_wdata
//
// A request is accepted in any cycle the queue has room; the back end emits one
// segment per cycle unless the output stalls; a character gives 1 to 9 segments.
// Reset empties the queue and output register and loads gaps 5, 3 and 7.
// A stalled output holds its segment; the queue keeps taking requests until full.
module morse_character_keyer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] light_on, [8:1] duration, [15:9] zero
  output logic        out_tlast,
  output logic        out_tuser,  // [0] invalid
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  mck_pkg::gaps_t           gaps_r;
  mck_pkg::desc_t           fe_desc, q_data;
  logic                     q_full, q_empty, q_pop;
  logic                     out_light_on;
  logic [mck_pkg::DurW-1:0] out_duration;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gaps_r.symbol_gap <= 8'd5;
      gaps_r.letter_gap <= 8'd3;
      gaps_r.word_gap   <= 8'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        mck_pkg::CFG_SYMBOL_GAP: gaps_r.symbol_gap <= cfg_wdata;
        mck_pkg::CFG_LETTER_GAP: gaps_r.letter_gap <= cfg_wdata;
        mck_pkg::CFG_WORD_GAP:   gaps_r.word_gap   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mck_front u_front (
    .character (in_tdata),
    .desc      (fe_desc)
  );

  assign in_tready = !q_full;

  mck_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_tvalid),
    .wr_data (fe_desc),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  mck_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .gaps         (gaps_r),
    .q_data       (q_data),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_light_on (out_light_on),
    .out_duration (out_duration),
    .out_last     (out_tlast),
    .out_invalid  (out_tuser)
  );

  assign out_tdata = {7'd0, out_duration, out_light_on};

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  a_invalid_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && !out_tdata[0] && out_tdata[8:1] == 8'd0)
    else $error("invalid segment not empty and final");

  a_light_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |->
      !out_tlast && !out_tuser && (out_tdata[8:1] == 8'd1 || out_tdata[8:1] == 8'd3))
    else $error("on segment is not a dot or dash");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

endmodule

@@ src/mck_front.sv @@
// Front end: classifies one character and looks up its Morse symbols.
// Depends on mck_pkg.
module mck_front (
  input  logic [mck_pkg::CharW-1:0] character,
  output mck_pkg::desc_t            desc
);

  logic [mck_pkg::CharW-1:0] folded;
  logic [mck_pkg::CharW-1:0] diff;
  logic [7:0]                code;
  logic                      is_letter;

  assign folded    = character & mck_pkg::CASE_MASK;
  assign diff      = folded - mck_pkg::FIRST_UPPER;
  assign is_letter = (folded >= mck_pkg::FIRST_UPPER) && (folded <= mck_pkg::LAST_UPPER);
  assign code      = mck_pkg::LETTER_CODE[diff[4:0]];

  always_comb begin
    desc.count = code[6:4];
    desc.dash  = code[3:0];
    if (character == mck_pkg::SPACE_CHAR) begin
      desc.kind = mck_pkg::KIND_SPACE;
    end else if (is_letter) begin
      desc.kind = mck_pkg::KIND_LETTER;
    end else begin
      desc.kind = mck_pkg::KIND_INVALID;
    end
  end

endmodule

@@ src/mck_queue.sv @@
// Short request queue between front and back end.
// Depends on mck_pkg for the descriptor type.
module mck_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  mck_pkg::desc_t wr_data,
  input  logic           rd_en,
  output mck_pkg::desc_t rd_data,
  output logic           full,
  output logic           empty
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW  = $clog2(DEPTH + 1);

  mck_pkg::desc_t   mem_r [DEPTH];
  logic [AddrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AddrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ src/mck_back.sv @@
// Back end: steps through the segments of one request, one per cycle unless the
// output stalls, into an output register. Depends on mck_pkg.
module mck_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mck_pkg::gaps_t           gaps,
  input  mck_pkg::desc_t           q_data,
  input  logic                     q_empty,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_light_on,
  output logic [mck_pkg::DurW-1:0] out_duration,
  output logic                     out_last,
  output logic                     out_invalid
);

  logic                     cur_valid_r, cur_valid_nxt;
  mck_pkg::desc_t           cur_desc_r;
  logic [3:0]               step_r, step_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     light_r, last_r, invalid_r;
  logic [mck_pkg::DurW-1:0] dur_r;

  logic                     seg_light, seg_last, seg_invalid;
  logic [mck_pkg::DurW-1:0] seg_dur;
  logic [3:0]               seg_total;
  logic                     advance, load;

  assign seg_total = {cur_desc_r.count, 1'b0};

  always_comb begin
    seg_light   = 1'b0;
    seg_dur     = '0;
    seg_last    = 1'b1;
    seg_invalid = 1'b0;
    case (cur_desc_r.kind)
      mck_pkg::KIND_LETTER: begin
        if (step_r < seg_total) begin
          seg_last = 1'b0;
          if (!step_r[0]) begin
            seg_light = 1'b1;
            seg_dur   = cur_desc_r.dash[step_r[2:1]] ? mck_pkg::DASH_TICKS
                                                      : mck_pkg::DOT_TICKS;
          end else begin
            seg_dur = gaps.symbol_gap;
          end
        end else begin
          seg_dur = gaps.letter_gap;
        end
      end
      mck_pkg::KIND_SPACE: begin
        seg_dur = gaps.word_gap;
      end
      default: begin
        seg_invalid = 1'b1;
      end
    endcase
  end

  assign advance = cur_valid_r && (!out_valid_r || out_ready);
  assign load    = !cur_valid_r || (advance && seg_last);
  assign q_pop   = load && !q_empty;

  always_comb begin
    cur_valid_nxt = load ? !q_empty : cur_valid_r;
    if (load) begin
      step_nxt = '0;
    end else if (advance) begin
      step_nxt = step_r + 1'b1;
    end else begin
      step_nxt = step_r;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_desc_r <= q_data;
    end
    if (advance) begin
      light_r   <= seg_light;
      dur_r     <= seg_dur;
      last_r    <= seg_last;
      invalid_r <= seg_invalid;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_light_on = light_r;
  assign out_duration = dur_r;
  assign out_last     = last_r;
  assign out_invalid  = invalid_r;

endmodule
